// ----- hw/rtl/parf_pkg.sv -----
// Package: types and constants shared by the phase-angle ramp firing unit.
`timescale 1ns / 1ps
`default_nettype none

package parf_pkg;

  // Width of the firing timer (at most 32).
  localparam int unsigned TimerBits = 16;

  localparam int unsigned DelayBits = 16;

  localparam logic [DelayBits-1:0] StartDelayReset = 16'd60000;
  localparam logic [DelayBits-1:0] MinDelayReset   = 16'd1000;
  localparam logic [DelayBits-1:0] DelayStepReset  = 16'd196;
  localparam logic [DelayBits-1:0] PulseWidthReset = 16'd2500;

  typedef enum logic [1:0] {
    RegStartDelay = 2'd0,
    RegMinDelay   = 2'd1,
    RegDelayStep  = 2'd2,
    RegPulseWidth = 2'd3
  } reg_index_e;

  typedef enum logic {
    OpTick = 1'b0,
    OpEdge = 1'b1
  } op_e;

  typedef struct packed {
    logic op;
    logic edge_rising;
  } in_word_t;

  typedef struct packed {
    logic                 gate;
    logic                 ramp_done;
    logic [DelayBits-1:0] current_delay;
  } out_word_t;

endpackage

`default_nettype wire

// ----- hw/rtl/phase_angle_ramp_firing_unit.sv -----
// Top level: phase-angle soft-start gate pulse generator with config port.
`timescale 1ns / 1ps
`default_nettype none

// Takes one word per clock: a timer tick or a mains zero-cross edge. Each accepted word
// yields exactly one result word in the next cycle, through a single output register; the
// firing state (timer, compare value, stored delay, phase) is updated in the accept cycle
// by one pass of compare/subtract logic, so a new word can be taken every cycle. Input is
// stalled only while the output register is full and its consumer stalls. Configuration
// writes are always ready and take effect on the next cycle; write start_delay only while
// no words are in flight. After the ramp finishes the gate holds high until reset.
module phase_angle_ramp_firing_unit
  import parf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire in_word_t             in_word_i,

  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      out_word_t            out_word_o,

  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [DelayBits-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhDelay = 2'd1,
    PhPulse = 2'd2,
    PhDone  = 2'd3
  } phase_e;

  logic [DelayBits-1:0] start_delay_q, start_delay_d;
  logic [DelayBits-1:0] min_delay_q, min_delay_d;
  logic [DelayBits-1:0] delay_step_q, delay_step_d;
  logic [DelayBits-1:0] pulse_width_q, pulse_width_d;

  logic [TimerBits-1:0] tick_q, tick_d;
  logic [TimerBits-1:0] match_q, match_d;
  logic [DelayBits-1:0] next_delay_q, next_delay_d;
  phase_e               phase_q, phase_d;
  logic                 want_rising_q, want_rising_d;
  logic                 gate_q, gate_d;

  logic                 out_valid_q, out_valid_d;
  out_word_t            out_word_q, out_word_d;

  logic                 in_accept;
  logic                 cfg_write;
  logic [TimerBits-1:0] tick_inc;
  logic [31:0]          next_delay_ext;
  logic [31:0]          pulse_width_ext;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign tick_inc        = tick_q + TimerBits'(1);
  // Compare loads are masked to the timer width (zero-extended when the timer is wider).
  assign next_delay_ext  = 32'(next_delay_q);
  assign pulse_width_ext = 32'(pulse_width_q);

  always_comb begin
    tick_d        = tick_q;
    match_d       = match_q;
    next_delay_d  = next_delay_q;
    phase_d       = phase_q;
    want_rising_d = want_rising_q;
    gate_d        = gate_q;

    if (in_accept && phase_q != PhDone) begin
      if (in_word_i.op == OpEdge) begin
        if (in_word_i.edge_rising == want_rising_q) begin
          tick_d       = '0;
          match_d      = next_delay_ext[TimerBits-1:0];
          gate_d       = 1'b0;
          next_delay_d = (next_delay_q > delay_step_q) ? (next_delay_q - delay_step_q) : '0;
          phase_d      = PhDelay;
        end
      end else begin
        tick_d = tick_inc;
        if (phase_q == PhDelay && tick_inc == match_q) begin
          tick_d        = '0;
          match_d       = pulse_width_ext[TimerBits-1:0];
          gate_d        = 1'b1;
          want_rising_d = ~want_rising_q;
          phase_d       = (next_delay_q < min_delay_q) ? PhDone : PhPulse;
        end else if (phase_q == PhPulse && tick_inc == match_q) begin
          gate_d  = 1'b0;
          phase_d = PhIdle;
        end
      end
    end

    if (phase_d == PhDone) begin
      gate_d = 1'b1;
    end

    start_delay_d = start_delay_q;
    min_delay_d   = min_delay_q;
    delay_step_d  = delay_step_q;
    pulse_width_d = pulse_width_q;
    if (cfg_write) begin
      unique case (reg_index_e'(cfg_index_i))
        RegStartDelay: begin
          start_delay_d = cfg_data_i;
          if (phase_q != PhDone) begin
            next_delay_d = cfg_data_i;
          end
        end
        RegMinDelay:   min_delay_d   = cfg_data_i;
        RegDelayStep:  delay_step_d  = cfg_data_i;
        RegPulseWidth: pulse_width_d = cfg_data_i;
        default: ;
      endcase
    end

    // Output register: loads on accept, drains when the consumer takes the word.
    out_valid_d = out_valid_q & out_stall_i;
    out_word_d  = out_word_q;
    if (in_accept) begin
      out_valid_d              = 1'b1;
      out_word_d.gate          = gate_d;
      out_word_d.ramp_done     = (phase_d == PhDone);
      out_word_d.current_delay = next_delay_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q <= StartDelayReset;
      min_delay_q   <= MinDelayReset;
      delay_step_q  <= DelayStepReset;
      pulse_width_q <= PulseWidthReset;
      tick_q        <= '0;
      match_q       <= '0;
      next_delay_q  <= StartDelayReset;
      phase_q       <= PhIdle;
      want_rising_q <= 1'b0;
      gate_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      start_delay_q <= start_delay_d;
      min_delay_q   <= min_delay_d;
      delay_step_q  <= delay_step_d;
      pulse_width_q <= pulse_width_d;
      tick_q        <= tick_d;
      match_q       <= match_d;
      next_delay_q  <= next_delay_d;
      phase_q       <= phase_d;
      want_rising_q <= want_rising_d;
      gate_q        <= gate_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

`ifndef SYNTHESIS
  // A finished ramp always reports the gate held on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.ramp_done |-> out_word_o.gate)
    else $error("ramp_done word without gate high");

  // Once done, the phase never leaves done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDone |=> phase_q == PhDone)
    else $error("left done phase");

  // Input only stalls when a word is held in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // Timer is frozen after the ramp ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDone |=> $stable(tick_q))
    else $error("timer moved after ramp done");
`endif

endmodule

`default_nettype wire
